// File: rtl/fmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared constants, widths and codes for the frame difference motion detector.
// ----------------------------------------------------------------------------
package fmd_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 131072;
  localparam int unsigned SAMPLE_STRIDE   = 4;
  localparam int unsigned BANK_SAMPLES    =
    (MAX_FRAME_BYTES + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE;

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(BANK_SAMPLES);
  localparam int unsigned PH_W  = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned CTHR_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic              DETECT_ENABLE_RST   = 1'b1;
  localparam logic [CTHR_W-1:0] COUNT_THRESHOLD_RST = CTHR_W'(15000);
  localparam logic [PIX_W-1:0]  PIXEL_THRESHOLD_RST = PIX_W'(25);
  localparam logic [TIME_W-1:0] COOLDOWN_MS_RST     = TIME_W'(2000);

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS     = 2'd3;

  typedef enum logic [2:0] {
    DEC_DISABLED = 3'd0,
    DEC_MANUAL   = 3'd1,
    DEC_COOLDOWN = 3'd2,
    DEC_FIRST    = 3'd3,
    DEC_MOTION   = 3'd4,
    DEC_NONE     = 3'd5
  } decision_t;

endpackage
`default_nettype wire

// File: rtl/fmd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/frame_difference_motion_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_difference_motion_detector_unit
// Samples a byte stream, compares it with the stored reference frame and
// reports a motion decision on each frame's last byte.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in_     | input     | in_valid/stall   | req_type, pixel_byte, last_byte, time_ms
// out_    | output    | out_valid/stall  | send_frame, changed_count, decision
// cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// One item per cycle while no result is held under out_stall. An accepted item
// is registered into stage 1 together with the sample store read; compare and
// decide work on stage 1 and the verdict is registered in the result register.
// Synchronous reset clears control state; the sample store is not cleared.
// A held result under out_stall freezes the whole pipe and raises in_stall.
// ----------------------------------------------------------------------------
module frame_difference_motion_detector_unit
  import fmd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic [PIX_W-1:0]     in_pixel_byte,
  input  wire logic                 in_last_byte,
  input  wire logic [TIME_W-1:0]    in_time_ms,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_send_frame,
  output logic [COUNT_W-1:0]        out_changed_count,
  output logic [2:0]                out_decision,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME_BYTES);
  localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(SAMPLE_STRIDE - 1);

  // configuration
  logic              det_en_r;
  logic [CTHR_W-1:0] cnt_thr_r;
  logic [PIX_W-1:0]  pix_thr_r;
  logic [TIME_W-1:0] cooldown_r;

  // handshake
  logic advance;
  logic in_acc;
  logic fb_acc;

  // stage 0 position tracking
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [PH_W-1:0]  ph_r, ph_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             sample0;
  logic [POS_W-1:0] len0;

  // stage 1
  logic              s1_valid_r;
  logic              s1_req_r;
  logic              s1_last_r;
  logic              s1_sample_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [POS_W-1:0]  s1_len_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [TIME_W-1:0] s1_time_r;

  // sample store
  logic [1:0]       wr_en;
  logic [PIX_W-1:0] rd_data0, rd_data1;
  logic [1:0]       fwd_hit_r;
  logic [PIX_W-1:0] fwd_data_r;
  logic [PIX_W-1:0] ref0, ref1, ref_pix;

  // detector state
  logic              ref_bank_r, ref_bank_nxt;
  logic [POS_W-1:0]  ref_len_r, ref_len_nxt;
  logic [COUNT_W-1:0] acc_r, acc_nxt;
  logic              trig_r, trig_nxt;
  logic              first_r, first_nxt;
  logic [TIME_W-1:0] last_motion_r, last_motion_nxt;

  logic               s1_fire;
  logic               s1_byte;
  logic [PIX_W-1:0]   diff;
  logic               hit;
  logic [COUNT_W-1:0] acc_inc;
  logic [TIME_W-1:0]  elapsed;

  logic               res_valid_nxt;
  logic               res_send_nxt;
  logic [COUNT_W-1:0] res_count_nxt;
  decision_t          res_dec_nxt;

  logic               out_valid_r;
  logic               out_send_r;
  logic [COUNT_W-1:0] out_count_r;
  decision_t          out_dec_r;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign in_acc   = in_valid && advance;
  assign fb_acc   = in_acc && (in_req_type == REQ_BYTE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_en_r   <= DETECT_ENABLE_RST;
      cnt_thr_r  <= COUNT_THRESHOLD_RST;
      pix_thr_r  <= PIXEL_THRESHOLD_RST;
      cooldown_r <= COOLDOWN_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DETECT_ENABLE:   det_en_r   <= cfg_data[0];
        CFG_COUNT_THRESHOLD: cnt_thr_r  <= cfg_data[CTHR_W-1:0];
        CFG_PIXEL_THRESHOLD: pix_thr_r  <= cfg_data[PIX_W-1:0];
        CFG_COOLDOWN_MS:     cooldown_r <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: position, stride phase and sample index
  assign sample0 = (pos_r < POS_MAX) && (ph_r == '0);
  assign len0    = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;

  always_comb begin
    pos_nxt = pos_r;
    ph_nxt  = ph_r;
    idx_nxt = idx_r;
    if (fb_acc) begin
      if (in_last_byte) begin
        pos_nxt = '0;
        ph_nxt  = '0;
        idx_nxt = '0;
      end else if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
        if (ph_r == PH_LAST) begin
          ph_nxt  = '0;
          idx_nxt = idx_r + IDX_W'(1);
        end else begin
          ph_nxt = ph_r + PH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ph_r  <= '0;
      idx_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ph_r  <= ph_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_req_r    <= in_req_type;
      s1_last_r   <= in_last_byte;
      s1_sample_r <= sample0;
      s1_pos_r    <= pos_r;
      s1_len_r    <= len0;
      s1_idx_r    <= idx_r;
      s1_pix_r    <= in_pixel_byte;
      s1_time_r   <= in_time_ms;
    end
  end

  // sample store: one RAM per bank, candidate written from stage 1
  assign s1_fire = advance && s1_valid_r;
  assign s1_byte = s1_fire && (s1_req_r == REQ_BYTE);

  assign wr_en[0] = s1_byte && s1_sample_r && ref_bank_r;
  assign wr_en[1] = s1_byte && s1_sample_r && !ref_bank_r;

  fmd_ram #(.WIDTH(PIX_W), .DEPTH(BANK_SAMPLES)) u_bank0 (
    .clk     (clk),
    .wr_en   (wr_en[0]),
    .wr_addr (s1_idx_r),
    .wr_data (s1_pix_r),
    .rd_en   (in_acc),
    .rd_addr (idx_r),
    .rd_data (rd_data0)
  );

  fmd_ram #(.WIDTH(PIX_W), .DEPTH(BANK_SAMPLES)) u_bank1 (
    .clk     (clk),
    .wr_en   (wr_en[1]),
    .wr_addr (s1_idx_r),
    .wr_data (s1_pix_r),
    .rd_en   (in_acc),
    .rd_addr (idx_r),
    .rd_data (rd_data1)
  );

  // forward a write that lands on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= '0;
    end else if (advance) begin
      fwd_hit_r[0] <= wr_en[0] && (s1_idx_r == idx_r);
      fwd_hit_r[1] <= wr_en[1] && (s1_idx_r == idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_data_r <= s1_pix_r;
    end
  end

  assign ref0    = fwd_hit_r[0] ? fwd_data_r : rd_data0;
  assign ref1    = fwd_hit_r[1] ? fwd_data_r : rd_data1;
  assign ref_pix = ref_bank_r ? ref1 : ref0;

  // stage 1: compare, count and decide
  assign diff    = (s1_pix_r > ref_pix) ? s1_pix_r - ref_pix : ref_pix - s1_pix_r;
  assign hit     = s1_sample_r && (s1_pos_r < ref_len_r) && (diff > pix_thr_r);
  assign acc_inc = (hit && (acc_r != COUNT_MAX)) ? acc_r + COUNT_W'(1) : acc_r;
  assign elapsed = s1_time_r - last_motion_r;

  always_comb begin
    ref_bank_nxt    = ref_bank_r;
    ref_len_nxt     = ref_len_r;
    acc_nxt         = acc_r;
    trig_nxt        = trig_r;
    first_nxt       = first_r;
    last_motion_nxt = last_motion_r;
    res_valid_nxt   = 1'b0;
    res_send_nxt    = 1'b0;
    res_count_nxt   = '0;
    res_dec_nxt     = DEC_NONE;
    if (s1_fire && (s1_req_r == REQ_TRIGGER)) begin
      trig_nxt = 1'b1;
    end else if (s1_byte && !s1_last_r) begin
      acc_nxt = acc_inc;
    end else if (s1_byte) begin
      res_valid_nxt = 1'b1;
      acc_nxt       = '0;
      if (!det_en_r) begin
        res_dec_nxt = DEC_DISABLED;
      end else if (trig_r) begin
        trig_nxt        = 1'b0;
        last_motion_nxt = s1_time_r;
        ref_bank_nxt    = !ref_bank_r;
        ref_len_nxt     = s1_len_r;
        res_dec_nxt     = DEC_MANUAL;
        res_send_nxt    = 1'b1;
      end else if (elapsed < cooldown_r) begin
        res_dec_nxt = DEC_COOLDOWN;
      end else if (first_r) begin
        first_nxt    = 1'b0;
        ref_bank_nxt = !ref_bank_r;
        ref_len_nxt  = s1_len_r;
        res_dec_nxt  = DEC_FIRST;
      end else begin
        res_count_nxt = acc_inc;
        if ({1'b0, acc_inc} > cnt_thr_r) begin
          last_motion_nxt = s1_time_r;
          ref_bank_nxt    = !ref_bank_r;
          ref_len_nxt     = s1_len_r;
          res_dec_nxt     = DEC_MOTION;
          res_send_nxt    = 1'b1;
        end else begin
          res_dec_nxt = DEC_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_bank_r    <= 1'b0;
      ref_len_r     <= '0;
      acc_r         <= '0;
      trig_r        <= 1'b0;
      first_r       <= 1'b1;
      last_motion_r <= '0;
    end else begin
      ref_bank_r    <= ref_bank_nxt;
      ref_len_r     <= ref_len_nxt;
      acc_r         <= acc_nxt;
      trig_r        <= trig_nxt;
      first_r       <= first_nxt;
      last_motion_r <= last_motion_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid_nxt) begin
      out_send_r  <= res_send_nxt;
      out_count_r <= res_count_nxt;
      out_dec_r   <= res_dec_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_send_frame    = out_send_r;
  assign out_changed_count = out_count_r;
  assign out_decision      = out_dec_r;

endmodule
`default_nettype wire

// File: tb/sv/frame_difference_motion_detector_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_motion_detector_unit_test
// Streams frames and manual trigger events into the motion detector. It keeps
// its own model of the sample banks, counters and decision rules, and checks
// every verdict field by field. It also covers wrapping cooldown time,
// disabled analysis and register truncation. Random idle bursts on both
// channels vary the timing.
// ----------------------------------------------------------------------------
module frame_difference_motion_detector_unit_test;
  import fmd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic              req_type;
    logic [PIX_W-1:0]  pixel;
    logic              last;
    logic [TIME_W-1:0] time_ms;
  } stream_item_t;

  typedef struct packed {
    logic               send;
    logic [COUNT_W-1:0] count;
    decision_t          dec;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = 1'b0;
  logic [PIX_W-1:0]     in_pixel_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic [TIME_W-1:0]    in_time_ms = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_send_frame;
  logic [COUNT_W-1:0]   out_changed_count;
  logic [2:0]           out_decision;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  frame_difference_motion_detector_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_pixel_byte     (in_pixel_byte),
    .in_last_byte      (in_last_byte),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_frame    (out_send_frame),
    .out_changed_count (out_changed_count),
    .out_decision      (out_decision),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // mirrored detector state
  logic              enable_cfg    = DETECT_ENABLE_RST;
  logic [CTHR_W-1:0] count_thr_cfg = COUNT_THRESHOLD_RST;
  logic [PIX_W-1:0]  pixel_thr_cfg = PIXEL_THRESHOLD_RST;
  logic [TIME_W-1:0] cooldown_cfg  = COOLDOWN_MS_RST;

  logic [PIX_W-1:0]   sample_mirror [2*BANK_SAMPLES];
  bit                 ref_bank      = 1'b0;
  int unsigned        ref_length    = 0;
  int unsigned        frame_pos     = 0;
  logic [COUNT_W-1:0] changed_acc   = '0;
  bit                 trigger_armed = 1'b0;
  bit                 await_first   = 1'b1;
  logic [TIME_W-1:0]  last_motion   = '0;

  stream_item_t stream_queue [$];
  verdict_t     expected_verdicts [$];
  stream_item_t cur_item;
  bit           item_taken = 1'b0;
  bit           quiet_tail = 1'b0;
  int unsigned  send_gap   = 0;
  int unsigned  stall_gap  = 0;

  int unsigned  cycle_count    = 0;
  int unsigned  fail_count     = 0;
  int unsigned  items_accepted = 0;
  int unsigned  triggers_taken = 0;
  int unsigned  verdict_tally [6] = '{default: 0};

  function automatic void predict_verdict(input stream_item_t it);
    int unsigned slot;
    int unsigned ref_base;
    int unsigned cand_base;
    logic [PIX_W-1:0] ref_pix;
    logic [PIX_W-1:0] diff;
    verdict_t v;
    if (it.req_type == REQ_TRIGGER) begin
      trigger_armed = 1'b1;
      return;
    end
    ref_base  = ref_bank ? BANK_SAMPLES : 0;
    cand_base = ref_bank ? 0 : BANK_SAMPLES;
    if (frame_pos < MAX_FRAME_BYTES && frame_pos % SAMPLE_STRIDE == 0) begin
      slot = frame_pos / SAMPLE_STRIDE;
      if (frame_pos < ref_length) begin
        ref_pix = sample_mirror[ref_base + slot];
        diff = (it.pixel > ref_pix) ? it.pixel - ref_pix : ref_pix - it.pixel;
        if (diff > pixel_thr_cfg && changed_acc != COUNT_MAX)
          changed_acc++;
      end
      sample_mirror[cand_base + slot] = it.pixel;
    end
    if (frame_pos < MAX_FRAME_BYTES)
      frame_pos++;
    if (!it.last)
      return;
    v.send  = 1'b0;
    v.count = '0;
    if (!enable_cfg) begin
      v.dec = DEC_DISABLED;
    end else if (trigger_armed) begin
      trigger_armed = 1'b0;
      last_motion = it.time_ms;
      ref_bank = !ref_bank;
      ref_length = frame_pos;
      v.dec = DEC_MANUAL;
      v.send = 1'b1;
    end else if (TIME_W'(it.time_ms - last_motion) < cooldown_cfg) begin
      v.dec = DEC_COOLDOWN;
    end else if (await_first) begin
      ref_bank = !ref_bank;
      ref_length = frame_pos;
      await_first = 1'b0;
      v.dec = DEC_FIRST;
    end else begin
      v.count = changed_acc;
      if (CTHR_W'(changed_acc) > count_thr_cfg) begin
        last_motion = it.time_ms;
        ref_bank = !ref_bank;
        ref_length = frame_pos;
        v.dec = DEC_MOTION;
        v.send = 1'b1;
      end else begin
        v.dec = DEC_NONE;
      end
    end
    frame_pos = 0;
    changed_acc = '0;
    expected_verdicts.push_back(v);
  endfunction

  task automatic push_item(input logic req, input logic [PIX_W-1:0] pix,
                           input logic last, input logic [TIME_W-1:0] t);
    stream_item_t it;
    it.req_type = req;
    it.pixel    = pix;
    it.last     = last;
    it.time_ms  = t;
    stream_queue.push_back(it);
  endtask

  task automatic settle();
    while (stream_queue.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DETECT_ENABLE:   enable_cfg    = data[0];
      CFG_COUNT_THRESHOLD: count_thr_cfg = data[CTHR_W-1:0];
      CFG_PIXEL_THRESHOLD: pixel_thr_cfg = data[PIX_W-1:0];
      CFG_COOLDOWN_MS:     cooldown_cfg  = data[TIME_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // driver: advance to the next pending item once the current one is taken
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_verdict(cur_item);
      item_taken = 1'b1;
      items_accepted++;
      if (cur_item.req_type == REQ_TRIGGER)
        triggers_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      item_taken = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (stream_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else begin
        cur_item = stream_queue.pop_front();
        in_valid      <= 1'b1;
        in_req_type   <= cur_item.req_type;
        in_pixel_byte <= cur_item.pixel;
        in_last_byte  <= cur_item.last;
        in_time_ms    <= cur_item.time_ms;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_gap != 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      stall_gap = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (out_decision <= DEC_NONE)
        verdict_tally[out_decision]++;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: send_frame %0d changed_count %0d decision %0d",
               out_send_frame, out_changed_count, out_decision);
        fail_count++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (out_send_frame !== exp_v.send) begin
          $error("send_frame mismatch: expected %0d, actual %0d",
                 exp_v.send, out_send_frame);
          fail_count++;
        end
        if (out_changed_count !== exp_v.count) begin
          $error("changed_count mismatch: expected %0d, actual %0d",
                 exp_v.count, out_changed_count);
          fail_count++;
        end
        if (out_decision !== exp_v.dec) begin
          $error("decision mismatch: expected %0d, actual %0d",
                 exp_v.dec, out_decision);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL frame_difference_motion_detector_unit");
      $finish;
    end
  end

  initial begin
    logic [PIX_W-1:0]  motif [64];
    logic [TIME_W-1:0] now_ms;
    logic [CTHR_W-1:0] cthr;
    logic [TIME_W-1:0] cool;
    logic [PIX_W-1:0]  pthr;
    logic [PIX_W-1:0]  pix;
    int unsigned       len;
    int unsigned       r;
    bit                fresh;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: manual, cooldown, first stored, no motion at reset settings
    push_item(REQ_TRIGGER, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    push_item(REQ_BYTE, 8'h00, 1'b1, 32'd10);
    push_item(REQ_BYTE, 8'hFF, 1'b1, 32'd500);
    push_item(REQ_BYTE, 8'h00, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h11, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h22, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h33, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'hFF, 1'b1, 32'h0001_0000);
    push_item(REQ_BYTE, 8'hFF, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h00, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h00, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h00, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h00, 1'b1, 32'h0002_0000);
    settle();

    // truncated writes: threshold becomes 0, pixel threshold 0
    write_register(CFG_COUNT_THRESHOLD, 32'hFFFE_0000);
    write_register(CFG_PIXEL_THRESHOLD, 32'h0000_0100);
    // cooldown across the 32-bit time wrap, then motion
    push_item(REQ_TRIGGER, 8'h00, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h80, 1'b1, 32'hFFFF_FF00);
    push_item(REQ_BYTE, 8'h80, 1'b1, 32'h0000_0100);
    push_item(REQ_BYTE, 8'h7F, 1'b1, 32'h0010_0000);
    settle();

    // disabled analysis keeps a pending trigger
    write_register(CFG_DETECT_ENABLE, 32'hFFFF_FFFE);
    push_item(REQ_TRIGGER, 8'h5A, 1'b1, 32'h1234_5678);
    push_item(REQ_BYTE, 8'hA5, 1'b0, 32'h0);
    push_item(REQ_BYTE, 8'h3C, 1'b1, 32'h0020_0000);
    settle();
    write_register(CFG_DETECT_ENABLE, 32'h0000_0001);
    push_item(REQ_BYTE, 8'hC3, 1'b1, 32'h0030_0000);
    settle();

    // random phases over a spread of settings
    foreach (motif[k]) motif[k] = PIX_W'($urandom);
    now_ms = 32'h0060_0000;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: cthr = '0;
        1: cthr = '1;
        default: cthr = CTHR_W'($urandom_range(0, 6));
      endcase
      case (p)
        0: pthr = '0;
        1: pthr = '1;
        default: pthr = PIX_W'($urandom_range(0, 60));
      endcase
      case (p)
        2: cool = 32'hFFFF_FFFF;
        4: cool = 32'd0;
        6: cool = COOLDOWN_MS_RST;
        default: cool = $urandom_range(0, 3000);
      endcase
      write_register(CFG_DETECT_ENABLE, {31'($urandom()), p != 3});
      write_register(CFG_COUNT_THRESHOLD, {15'($urandom()), cthr});
      write_register(CFG_PIXEL_THRESHOLD, {24'($urandom()), pthr});
      write_register(CFG_COOLDOWN_MS, cool);
      if (p == 7)
        quiet_tail = 1'b1;
      for (int f = 0; f < 6; f++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        fresh = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 7) == 0)
          push_item(REQ_TRIGGER, PIX_W'($urandom), 1'($urandom), $urandom);
        for (int unsigned i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0)
            push_item(REQ_TRIGGER, PIX_W'($urandom), 1'($urandom), $urandom);
          pix = fresh ? PIX_W'($urandom) : motif[i % 64] + PIX_W'($urandom_range(0, 2));
          push_item(REQ_BYTE, pix, i == len - 1, (i == len - 1) ? now_ms : $urandom);
        end
        r = $urandom_range(0, 19);
        if (r == 0)
          now_ms = $urandom;
        else if (r == 1)
          now_ms = 32'hFFFF_FFFF - $urandom_range(0, 1500);
        else
          now_ms = now_ms + $urandom_range(0, 2500);
        if ($urandom_range(0, 3) == 0)
          foreach (motif[k]) motif[k] = PIX_W'($urandom);
      end
      settle();
    end

    $display("Run took %0d items (%0d trigger events) in %0d cycles.",
             items_accepted, triggers_taken, cycle_count);
    $display("Verdicts: disabled %0d, manual %0d, cooldown %0d, first %0d, motion %0d, none %0d",
             verdict_tally[DEC_DISABLED], verdict_tally[DEC_MANUAL],
             verdict_tally[DEC_COOLDOWN], verdict_tally[DEC_FIRST],
             verdict_tally[DEC_MOTION], verdict_tally[DEC_NONE]);
    if (fail_count == 0)
      $display("PASS frame_difference_motion_detector_unit");
    else
      $display("FAIL frame_difference_motion_detector_unit");
    $finish;
  end

endmodule

// File: sim.f
rtl/fmd_pkg.sv
rtl/fmd_ram.sv
rtl/frame_difference_motion_detector_unit.sv
tb/sv/frame_difference_motion_detector_unit_test.sv
